FILE: hw/rtl/ktts_pkg.sv
package ktts_pkg;

    // configuration register indexes
    localparam int unsigned CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CFG_CURSOR_APP  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_NEWLINE     = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_LOCAL_ECHO  = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_SCREEN_ROWS = 2'd3;
    localparam logic [7:0]         ROWS_RESET      = 8'd24;

    // keysyms
    localparam logic [15:0] KEY_SHIFT_L   = 16'hFFE1;
    localparam logic [15:0] KEY_SHIFT_R   = 16'hFFE2;
    localparam logic [15:0] KEY_CTRL      = 16'hFFE3;
    localparam logic [15:0] KEY_ALT       = 16'hFFE9;
    localparam logic [15:0] KEY_PAGE_DOWN = 16'hFF56;
    localparam logic [15:0] KEY_PAGE_UP   = 16'hFF55;
    localparam logic [15:0] KEY_ENTER     = 16'hFF0D;
    localparam logic [15:0] KEY_KP_ENTER  = 16'hFF8D;
    localparam logic [15:0] KEY_UP        = 16'hFF52;
    localparam logic [15:0] KEY_DOWN      = 16'hFF54;
    localparam logic [15:0] KEY_LEFT      = 16'hFF51;
    localparam logic [15:0] KEY_RIGHT     = 16'hFF53;
    localparam logic [15:0] KEY_BACKSPACE = 16'hFF08;
    localparam logic [15:0] KEY_TAB       = 16'hFF09;
    localparam logic [15:0] KEY_ESCAPE    = 16'hFF1B;
    localparam logic [15:0] KEY_END       = 16'hFF57;
    localparam logic [15:0] KEY_HOME      = 16'hFF50;
    localparam logic [15:0] KEY_DELETE    = 16'hFFFF;
    localparam logic [15:0] KEY_INSERT    = 16'hFF63;
    localparam logic [15:0] KEY_TABLE_MIN = 16'd255;

    // ascii
    localparam logic [7:0] CH_ESC   = 8'h1b;
    localparam logic [7:0] CH_CSI   = 8'h5b;
    localparam logic [7:0] CH_SS3   = 8'h4f;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_5     = 8'h35;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_TILDE = 8'h7e;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7a;
    localparam logic [7:0] CH_RBRK  = 8'h5d;
    localparam logic [7:0] CTRL_RBRK = 8'h1d;
    localparam logic [7:0] CTRL_OFS  = 8'h60;

    typedef struct packed {
        logic       cursor_app;
        logic       newline;
        logic       local_echo;
        logic [7:0] screen_rows;
    } t_cfg;

    // decoded event, up to four results
    typedef struct packed {
        logic              action;
        logic [3:0][7:0]   bytes;
        logic signed [7:0] scroll;
        logic              echo;
        logic              clear;
        logic [1:0]        last_idx;
    } t_seq;

    typedef struct packed {
        logic            found;
        logic            arrow;
        logic [1:0]      last_idx;
        logic [3:0][7:0] bytes;
    } t_rom;

    function automatic t_rom mk_rom(input logic [1:0] last_idx, input logic arrow,
                                    input logic [7:0] b0, input logic [7:0] b1,
                                    input logic [7:0] b2, input logic [7:0] b3);
        t_rom r;
        r.found    = 1'b1;
        r.arrow    = arrow;
        r.last_idx = last_idx;
        r.bytes[0] = b0;
        r.bytes[1] = b1;
        r.bytes[2] = b2;
        r.bytes[3] = b3;
        return r;
    endfunction

    function automatic t_rom seq_lookup(input logic [15:0] key);
        t_rom r;
        r = '0;
        case (key)
            KEY_UP:        r = mk_rom(2'd2, 1'b1, CH_ESC, CH_CSI, CH_A, 8'h00);
            KEY_DOWN:      r = mk_rom(2'd2, 1'b1, CH_ESC, CH_CSI, CH_B, 8'h00);
            KEY_LEFT:      r = mk_rom(2'd2, 1'b1, CH_ESC, CH_CSI, CH_D, 8'h00);
            KEY_RIGHT:     r = mk_rom(2'd2, 1'b1, CH_ESC, CH_CSI, CH_C, 8'h00);
            KEY_BACKSPACE: r = mk_rom(2'd0, 1'b0, CH_BS, 8'h00, 8'h00, 8'h00);
            KEY_TAB:       r = mk_rom(2'd0, 1'b0, CH_TAB, 8'h00, 8'h00, 8'h00);
            KEY_ESCAPE:    r = mk_rom(2'd0, 1'b0, CH_ESC, 8'h00, 8'h00, 8'h00);
            KEY_PAGE_DOWN: r = mk_rom(2'd3, 1'b0, CH_ESC, CH_CSI, CH_6, CH_TILDE);
            KEY_PAGE_UP:   r = mk_rom(2'd3, 1'b0, CH_ESC, CH_CSI, CH_5, CH_TILDE);
            KEY_END:       r = mk_rom(2'd2, 1'b0, CH_ESC, CH_CSI, CH_F, 8'h00);
            KEY_HOME:      r = mk_rom(2'd2, 1'b0, CH_ESC, CH_CSI, CH_H, 8'h00);
            KEY_DELETE:    r = mk_rom(2'd3, 1'b0, CH_ESC, CH_CSI, CH_3, CH_TILDE);
            KEY_INSERT:    r = mk_rom(2'd3, 1'b0, CH_ESC, CH_CSI, CH_4, CH_TILDE);
            default:       r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/ktts_key_if.sv
interface ktts_key_if;
    logic        valid;
    logic        ready;
    logic [15:0] key_code;
    logic        pressed;
    logic        shift_lock;
    logic [15:0] shifted_code;

    modport source (output valid, output key_code, output pressed, output shift_lock,
                    output shifted_code, input ready);
    modport sink (input valid, input key_code, input pressed, input shift_lock,
                  input shifted_code, output ready);
endinterface

FILE: hw/rtl/ktts_res_if.sv
interface ktts_res_if;
    logic              valid;
    logic              ready;
    logic              action;
    logic [7:0]        out_byte;
    logic signed [7:0] scroll_lines;
    logic              echo_too;
    logic              clear_scrollback;
    logic              last;

    modport source (output valid, output action, output out_byte, output scroll_lines,
                    output echo_too, output clear_scrollback, output last, input ready);
    modport sink (input valid, input action, input out_byte, input scroll_lines,
                  input echo_too, input clear_scrollback, input last, output ready);
endinterface

FILE: hw/rtl/ktts_decode.sv
module ktts_decode (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ktts_key_if.sink       i_key_if,
    input  ktts_pkg::t_cfg i_cfg,
    output ktts_pkg::t_seq o_seq,
    output logic           o_seq_valid,
    input  logic           i_seq_ready
);
    import ktts_pkg::*;

    logic        r_in_vld;
    logic [15:0] r_key_code;
    logic        r_pressed;
    logic        r_shift_lock;
    logic [15:0] r_shifted_code;
    logic        r_shift_down;
    logic        r_ctrl_down;
    logic        r_alt_down;
    logic        n_shift_down;
    logic        n_ctrl_down;
    logic        n_alt_down;

    logic        is_shift;
    logic        is_ctrl;
    logic        is_alt;
    logic        is_page;
    logic        is_enter;
    logic        has_res;
    logic        consume;
    logic [7:0]  half_rows;
    logic [7:0]  code;
    t_rom        rom;
    t_seq        seq;

    assign is_shift = (r_key_code == KEY_SHIFT_L) || (r_key_code == KEY_SHIFT_R);
    assign is_ctrl  = (r_key_code == KEY_CTRL);
    assign is_alt   = (r_key_code == KEY_ALT);
    assign is_page  = (r_key_code == KEY_PAGE_DOWN) || (r_key_code == KEY_PAGE_UP);
    assign is_enter = (r_key_code == KEY_ENTER) || (r_key_code == KEY_KP_ENTER);
    assign half_rows = {1'b0, i_cfg.screen_rows[7:1]};
    assign rom = seq_lookup(r_key_code);

    // code below the table range: shift lock wins over control
    always_comb begin
        code = r_key_code[7:0];
        if (r_shift_lock) begin
            code = r_shifted_code[7:0];
        end else if (r_ctrl_down) begin
            if (r_key_code[7:0] >= CH_LOW_A && r_key_code[7:0] <= CH_LOW_Z) begin
                code = r_key_code[7:0] - CTRL_OFS;
            end else if (r_key_code[7:0] == CH_RBRK) begin
                code = CTRL_RBRK;
            end
        end
    end

    always_comb begin
        seq      = '0;
        seq.echo = i_cfg.local_echo;
        has_res  = 1'b0;
        if (is_shift || is_ctrl || is_alt || !r_pressed) begin
            has_res = 1'b0;
        end else if (r_shift_down && is_page) begin
            has_res     = 1'b1;
            seq.action  = 1'b1;
            seq.echo    = 1'b0;
            seq.scroll  = (r_key_code == KEY_PAGE_DOWN) ? -half_rows : half_rows;
        end else if (is_enter) begin
            has_res      = 1'b1;
            seq.clear    = 1'b1;
            seq.bytes[0] = CH_CR;
            seq.bytes[1] = CH_LF;
            seq.last_idx = {1'b0, i_cfg.newline};
        end else if (r_key_code >= KEY_TABLE_MIN) begin
            has_res      = rom.found;
            seq.bytes    = rom.bytes;
            seq.last_idx = rom.last_idx;
            if (rom.arrow && i_cfg.cursor_app) begin
                seq.bytes[1] = CH_SS3;
            end
        end else begin
            has_res      = 1'b1;
            seq.bytes[0] = code;
        end
    end

    assign consume         = r_in_vld && (!has_res || i_seq_ready);
    assign o_seq_valid     = r_in_vld && has_res;
    assign o_seq           = seq;
    assign i_key_if.ready  = !r_in_vld || consume;

    always_comb begin
        n_shift_down = r_shift_down;
        n_ctrl_down  = r_ctrl_down;
        n_alt_down   = r_alt_down;
        if (consume && is_shift) begin
            n_shift_down = r_pressed;
        end
        if (consume && is_ctrl) begin
            n_ctrl_down = r_pressed;
        end
        if (consume && is_alt) begin
            n_alt_down = r_pressed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_shift_down <= 1'b0;
            r_ctrl_down  <= 1'b0;
            r_alt_down   <= 1'b0;
        end else begin
            r_shift_down <= n_shift_down;
            r_ctrl_down  <= n_ctrl_down;
            r_alt_down   <= n_alt_down;
            if (i_key_if.ready) begin
                r_in_vld <= i_key_if.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_key_if.valid && i_key_if.ready) begin
            r_key_code     <= i_key_if.key_code;
            r_pressed      <= i_key_if.pressed;
            r_shift_lock   <= i_key_if.shift_lock;
            r_shifted_code <= i_key_if.shifted_code;
        end
    end

    // modifier events never wait on the serializer
    a_ctrl_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && is_ctrl) |=> (r_ctrl_down == $past(r_pressed)))
        else $error("control flag not updated");

    a_mod_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && (is_shift || is_ctrl || is_alt)) |-> (!o_seq_valid && consume))
        else $error("modifier event produced a result");

endmodule

FILE: hw/rtl/ktts_serializer.sv
module ktts_serializer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ktts_pkg::t_seq i_seq,
    input  logic           i_seq_valid,
    output logic           o_seq_ready,
    ktts_res_if.source     o_res_if
);
    import ktts_pkg::*;

    typedef struct packed {
        logic              action;
        logic [7:0]        out_byte;
        logic signed [7:0] scroll_lines;
        logic              echo_too;
        logic              clear_scrollback;
        logic              last;
    } t_res;

    t_seq       r_seq;
    logic       r_seq_vld;
    logic [1:0] r_idx;
    t_res       r_out;
    logic       r_out_vld;

    logic       out_adv;
    logic       emit;
    logic       at_last;
    logic       emit_last;
    t_res       n_out;

    assign out_adv     = !r_out_vld || o_res_if.ready;
    assign emit        = r_seq_vld && out_adv;
    assign at_last     = (r_idx == r_seq.last_idx);
    assign emit_last   = emit && at_last;
    assign o_seq_ready = !r_seq_vld || emit_last;

    always_comb begin
        n_out.action           = r_seq.action;
        n_out.out_byte         = r_seq.bytes[r_idx];
        n_out.scroll_lines     = r_seq.scroll;
        n_out.echo_too         = r_seq.echo;
        n_out.clear_scrollback = r_seq.clear;
        n_out.last             = at_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_vld <= 1'b0;
            r_idx     <= 2'd0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_seq_valid && o_seq_ready) begin
                r_seq_vld <= 1'b1;
                r_idx     <= 2'd0;
            end else if (emit_last) begin
                r_seq_vld <= 1'b0;
            end else if (emit) begin
                r_idx <= r_idx + 2'd1;
            end
            if (out_adv) begin
                r_out_vld <= r_seq_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_seq_valid && o_seq_ready) begin
            r_seq <= i_seq;
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_res_if.valid            = r_out_vld;
    assign o_res_if.action           = r_out.action;
    assign o_res_if.out_byte         = r_out.out_byte;
    assign o_res_if.scroll_lines     = r_out.scroll_lines;
    assign o_res_if.echo_too         = r_out.echo_too;
    assign o_res_if.clear_scrollback = r_out.clear_scrollback;
    assign o_res_if.last             = r_out.last;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq_vld |-> (r_idx <= r_seq.last_idx))
        else $error("byte index past end of sequence");

    a_scroll_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.action) |-> (r_out.last && r_out.out_byte == 8'h00
                                         && !r_out.echo_too))
        else $error("scroll result malformed");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq_vld && r_out_vld && !o_res_if.ready) |=> (r_seq_vld && $stable(r_idx)))
        else $error("sequence advanced while output stalled");

endmodule

FILE: hw/rtl/key_to_terminal_sequence_unit.sv
// key event to vt100 host byte encoder
//
// i_key_if takes one key event per transaction (keysym, pressed flag, shift lock and
// the shifted code). o_res_if gives one result per transaction: a host byte or a
// scroll command, with last set on the final result of the event.
// config is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data), to be written only
// while the block is idle; the block itself does not enforce this.
//
// an accepted event is registered, decoded into a sequence buffer, and its results
// then pass one at a time through the output register.
// throughput: one result per cycle while the receiver is ready, set by the single
// output register. an event of n results (n from 1 to 4) holds the serializer
// until its last result is out; events without a result (modifiers, key releases,
// unmapped keys) are consumed in the decoder and never reach the serializer.
// the input side keeps accepting while the buffer or output register is full,
// as long as the decode stage can hand its event on.
//
// reset clears the held modifier flags, all valid flags and the config registers
// (screen_rows back to 24). when the receiver stalls, the output holds and the
// stall backs up through the sequence buffer to i_key_if.ready.
module key_to_terminal_sequence_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ktts_key_if.sink                        i_key_if,
    ktts_res_if.source                      o_res_if,
    input  logic                            i_cfg_we,
    input  logic [ktts_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [7:0]                      i_cfg_data
);
    import ktts_pkg::*;

    t_cfg r_cfg;
    t_seq seq;
    logic seq_valid;
    logic seq_ready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cursor_app  <= 1'b0;
            r_cfg.newline     <= 1'b0;
            r_cfg.local_echo  <= 1'b0;
            r_cfg.screen_rows <= ROWS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CURSOR_APP:  r_cfg.cursor_app  <= i_cfg_data[0];
                CFG_NEWLINE:     r_cfg.newline     <= i_cfg_data[0];
                CFG_LOCAL_ECHO:  r_cfg.local_echo  <= i_cfg_data[0];
                CFG_SCREEN_ROWS: r_cfg.screen_rows <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // event register, modifier tracking and sequence decode
    ktts_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key_if    (i_key_if),
        .i_cfg       (r_cfg),
        .o_seq       (seq),
        .o_seq_valid (seq_valid),
        .i_seq_ready (seq_ready)
    );

    // sequence buffer and output register, one result per cycle while the receiver is ready
    ktts_serializer u_serializer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seq       (seq),
        .i_seq_valid (seq_valid),
        .o_seq_ready (seq_ready),
        .o_res_if    (o_res_if)
    );

endmodule

FILE: test/key_to_terminal_sequence_unit_tb.sv
`timescale 1ns / 100ps

module key_to_terminal_sequence_unit_tb;

    // keysyms
    localparam logic [15:0] KS_SHIFT_L   = 16'd65505;
    localparam logic [15:0] KS_SHIFT_R   = 16'd65506;
    localparam logic [15:0] KS_CTRL      = 16'd65507;
    localparam logic [15:0] KS_ALT       = 16'd65513;
    localparam logic [15:0] KS_PAGE_DOWN = 16'd65366;
    localparam logic [15:0] KS_PAGE_UP   = 16'd65365;
    localparam logic [15:0] KS_ENTER     = 16'd65293;
    localparam logic [15:0] KS_KP_ENTER  = 16'd65421;
    localparam logic [15:0] KS_UP        = 16'd65362;
    localparam logic [15:0] KS_DOWN      = 16'd65364;
    localparam logic [15:0] KS_LEFT      = 16'd65361;
    localparam logic [15:0] KS_RIGHT     = 16'd65363;
    localparam logic [15:0] KS_BACKSPACE = 16'd65288;
    localparam logic [15:0] KS_TAB       = 16'd65289;
    localparam logic [15:0] KS_ESCAPE    = 16'd65307;
    localparam logic [15:0] KS_END       = 16'd65367;
    localparam logic [15:0] KS_HOME      = 16'd65360;
    localparam logic [15:0] KS_DELETE    = 16'd65535;
    localparam logic [15:0] KS_INSERT    = 16'd65379;
    localparam logic [15:0] KS_FIRST_SYM = 16'd255;
    localparam logic [15:0] KS_UNMAPPED  = 16'd65534;

    // host bytes
    localparam logic [7:0] B_ESC       = 8'h1b;
    localparam logic [7:0] B_CSI       = "[";
    localparam logic [7:0] B_SS3       = "O";
    localparam logic [7:0] B_CR        = 8'h0d;
    localparam logic [7:0] B_LF        = 8'h0a;
    localparam logic [7:0] B_BS        = 8'h08;
    localparam logic [7:0] B_TAB       = 8'h09;
    localparam logic [7:0] B_CTRL_RBRK = 8'h1d;
    localparam logic [7:0] ROWS_AT_RESET = 8'd24;

    localparam logic ACT_BYTE   = 1'b0;
    localparam logic ACT_SCROLL = 1'b1;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int LONG_HOLD    = 120;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic              action;
        logic [7:0]        out_byte;
        logic signed [7:0] scroll_lines;
        logic              echo_too;
        logic              clear_scrollback;
        logic              last;
    } t_host_result;

    typedef struct packed {
        logic [15:0] key_code;
        logic        pressed;
        logic        shift_lock;
        logic [15:0] shifted_code;
    } t_key_event;

    // keeps its own copy of the modifier flags and registers, turns each accepted
    // key event into the host results it should cause and checks them in order
    class host_byte_scoreboard;
        t_host_result   expected_results[$];
        ktts_pkg::t_cfg regs;
        bit             shift_state;
        bit             ctrl_state;
        bit             alt_state;
        int             errors;

        function new();
            regs             = '0;
            regs.screen_rows = ROWS_AT_RESET;
            shift_state      = 1'b0;
            ctrl_state       = 1'b0;
            alt_state        = 1'b0;
            errors           = 0;
        endfunction

        function void set_reg(input logic [ktts_pkg::CfgIdxW-1:0] idx, input logic [7:0] data);
            case (idx)
                ktts_pkg::CFG_CURSOR_APP:  regs.cursor_app  = data[0];
                ktts_pkg::CFG_NEWLINE:     regs.newline     = data[0];
                ktts_pkg::CFG_LOCAL_ECHO:  regs.local_echo  = data[0];
                ktts_pkg::CFG_SCREEN_ROWS: regs.screen_rows = data;
                default: ;
            endcase
        endfunction

        function void push_bytes(input logic [0:3][7:0] seq, input int count, input logic clear);
            t_host_result r;
            for (int i = 0; i < count; i++) begin
                r.action           = ACT_BYTE;
                r.out_byte         = seq[i];
                r.scroll_lines     = '0;
                r.echo_too         = regs.local_echo;
                r.clear_scrollback = clear;
                r.last             = (i == count - 1);
                expected_results.push_back(r);
            end
        endfunction

        function void note_key(input t_key_event ev);
            t_host_result      r;
            logic [7:0]        half;
            logic [7:0]        intro;
            logic [0:3][7:0]   seq;
            logic [15:0]       code;
            int                count;

            case (ev.key_code)
                KS_SHIFT_L, KS_SHIFT_R: begin
                    shift_state = ev.pressed;
                    return;
                end
                KS_CTRL: begin
                    ctrl_state = ev.pressed;
                    return;
                end
                KS_ALT: begin
                    alt_state = ev.pressed;
                    return;
                end
                default: ;
            endcase
            if (!ev.pressed)
                return;

            // shift with page keys scrolls the view by half the screen
            if (shift_state && (ev.key_code == KS_PAGE_DOWN || ev.key_code == KS_PAGE_UP)) begin
                half               = regs.screen_rows >> 1;
                r.action           = ACT_SCROLL;
                r.out_byte         = '0;
                r.scroll_lines     = (ev.key_code == KS_PAGE_DOWN) ? 8'd0 - half : half;
                r.echo_too         = 1'b0;
                r.clear_scrollback = 1'b0;
                r.last             = 1'b1;
                expected_results.push_back(r);
                return;
            end

            if (ev.key_code == KS_ENTER || ev.key_code == KS_KP_ENTER) begin
                push_bytes({B_CR, B_LF, 16'h0000}, regs.newline ? 2 : 1, 1'b1);
                return;
            end

            if (ev.key_code >= KS_FIRST_SYM) begin
                intro = regs.cursor_app ? B_SS3 : B_CSI;
                count = 0;
                case (ev.key_code)
                    KS_UP:        begin seq = {B_ESC, intro, "A", 8'h00}; count = 3; end
                    KS_DOWN:      begin seq = {B_ESC, intro, "B", 8'h00}; count = 3; end
                    KS_LEFT:      begin seq = {B_ESC, intro, "D", 8'h00}; count = 3; end
                    KS_RIGHT:     begin seq = {B_ESC, intro, "C", 8'h00}; count = 3; end
                    KS_BACKSPACE: begin seq = {B_BS, 24'h0};              count = 1; end
                    KS_TAB:       begin seq = {B_TAB, 24'h0};             count = 1; end
                    KS_ESCAPE:    begin seq = {B_ESC, 24'h0};             count = 1; end
                    KS_PAGE_DOWN: begin seq = {B_ESC, "[6~"};             count = 4; end
                    KS_PAGE_UP:   begin seq = {B_ESC, "[5~"};             count = 4; end
                    KS_END:       begin seq = {B_ESC, B_CSI, "F", 8'h00}; count = 3; end
                    KS_HOME:      begin seq = {B_ESC, B_CSI, "H", 8'h00}; count = 3; end
                    KS_DELETE:    begin seq = {B_ESC, "[3~"};             count = 4; end
                    KS_INSERT:    begin seq = {B_ESC, "[4~"};             count = 4; end
                    default:      seq = '0;
                endcase
                push_bytes(seq, count, 1'b0);
                return;
            end

            // single byte: shift lock wins over control
            code = ev.key_code;
            if (ev.shift_lock)
                code = ev.shifted_code;
            else if (ctrl_state) begin
                if (ev.key_code >= "a" && ev.key_code <= "z")
                    code = ev.key_code - "a" + 16'd1;
                else if (ev.key_code == "]")
                    code = {8'h00, B_CTRL_RBRK};
            end
            push_bytes({code[7:0], 24'h0}, 1, 1'b0);
        endfunction

        function void check_result(input t_host_result got);
            t_host_result want;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected result: act=%0d byte=%h scroll=%0d echo=%0d clr=%0d",
                             got.action, got.out_byte, got.scroll_lines, got.echo_too,
                             got.clear_scrollback);
                return;
            end
            want = expected_results.pop_front();
            if (got.action !== want.action || got.out_byte !== want.out_byte ||
                got.scroll_lines !== want.scroll_lines || got.echo_too !== want.echo_too ||
                got.clear_scrollback !== want.clear_scrollback || got.last !== want.last) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("mismatch: expected act=%0d byte=%h scroll=%0d echo=%0d clr=%0d last=%0d",
                             want.action, want.out_byte, want.scroll_lines, want.echo_too,
                             want.clear_scrollback, want.last);
                    $display("          got      act=%0d byte=%h scroll=%0d echo=%0d clr=%0d last=%0d",
                             got.action, got.out_byte, got.scroll_lines, got.echo_too,
                             got.clear_scrollback, got.last);
                end
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [ktts_pkg::CfgIdxW-1:0] i_cfg_idx;
    logic [7:0]                   i_cfg_data;

    ktts_key_if kif ();
    ktts_res_if rif ();

    host_byte_scoreboard sb = new();

    int cycle_count;
    int burst_left;
    bit hold_request;

    key_to_terminal_sequence_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key_if   (kif),
        .o_res_if   (rif),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // input monitor: every accepted key transaction goes to the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && kif.valid && kif.ready)
            sb.note_key({kif.key_code, kif.pressed, kif.shift_lock, kif.shifted_code});
    end

    // output monitor: every accepted result transaction is checked against the oldest one
    always @(posedge i_clk) begin
        if (i_rst_n && rif.valid && rif.ready)
            sb.check_result({rif.action, rif.out_byte, rif.scroll_lines, rif.echo_too,
                             rif.clear_scrollback, rif.last});
    end

    // receiver: the stall pattern is picked anew at random each time mode_age wraps; a
    // hold request drops ready for a long stretch so the block backs up to its input
    initial begin : receiver
        int hold_left;
        int mode_age;
        int rx_mode;
        hold_left = 0;
        mode_age  = 0;
        rx_mode   = 0;
        rif.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            mode_age++;
            if (mode_age >= 50) begin
                mode_age = 0;
                rx_mode  = $urandom_range(0, 3);
            end
            if (hold_left > 0) begin
                hold_left--;
                rif.ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0:       rif.ready <= 1'b1;                          // never stalls
                    1:       rif.ready <= mode_age[0];                   // alternating ready
                    2:       rif.ready <= ($urandom_range(0, 3) != 0);   // light stalls
                    default: rif.ready <= ($urandom_range(0, 3) == 0);   // heavy stalls
                endcase
            end
        end
    end

    // offer one key event and hold it until accepted; bursts of random
    // length are followed by random gaps with valid low
    task automatic send_key(input logic [15:0] code, input logic down, input logic lock,
                            input logic [15:0] alt_code);
        kif.valid        <= 1'b1;
        kif.key_code     <= code;
        kif.pressed      <= down;
        kif.shift_lock   <= lock;
        kif.shifted_code <= alt_code;
        @(posedge i_clk);
        while (!kif.ready)
            @(posedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            kif.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 30)
                                                     : $urandom_range(1, 6);
        end
    endtask

    // mostly well-formed key events with random content, some noise
    function automatic t_key_event random_key_event();
        t_key_event ev;
        int         pick;
        pick            = $urandom_range(0, 99);
        ev.key_code     = 16'($urandom);
        ev.pressed      = ($urandom_range(0, 9) != 0);
        ev.shift_lock   = ($urandom_range(0, 3) == 0);
        ev.shifted_code = 16'($urandom);
        if (pick < 35) begin
            ev.key_code = 16'($urandom_range(0, 254));
        end else if (pick < 55) begin
            case ($urandom_range(0, 12))
                0:       ev.key_code = KS_UP;
                1:       ev.key_code = KS_DOWN;
                2:       ev.key_code = KS_LEFT;
                3:       ev.key_code = KS_RIGHT;
                4:       ev.key_code = KS_BACKSPACE;
                5:       ev.key_code = KS_TAB;
                6:       ev.key_code = KS_ESCAPE;
                7:       ev.key_code = KS_PAGE_DOWN;
                8:       ev.key_code = KS_PAGE_UP;
                9:       ev.key_code = KS_END;
                10:      ev.key_code = KS_HOME;
                11:      ev.key_code = KS_DELETE;
                default: ev.key_code = KS_INSERT;
            endcase
        end else if (pick < 63) begin
            ev.key_code = $urandom_range(0, 1) ? KS_ENTER : KS_KP_ENTER;
        end else if (pick < 75) begin
            // modifier transitions, held about half the time
            ev.pressed = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0:       ev.key_code = KS_SHIFT_L;
                1:       ev.key_code = KS_SHIFT_R;
                2:       ev.key_code = KS_CTRL;
                default: ev.key_code = KS_ALT;
            endcase
        end else if (pick < 85) begin
            ev.key_code = $urandom_range(0, 1) ? KS_PAGE_DOWN : KS_PAGE_UP;
        end else begin
            // noise: any keysym, either direction
            ev.pressed = 1'($urandom_range(0, 1));
        end
        return ev;
    endfunction

    task automatic send_random(input int count);
        t_key_event ev;
        for (int i = 0; i < count; i++) begin
            ev = random_key_event();
            send_key(ev.key_code, ev.pressed, ev.shift_lock, ev.shifted_code);
        end
    endtask

    // wait until every expected result has come, then let any event that
    // makes no result clear the pipeline
    task automatic settle();
        kif.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [ktts_pkg::CfgIdxW-1:0] idx, input logic [7:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    // write enable stays high across the four writes and drops once
    task automatic set_config(input logic cursor_app, input logic newline, input logic echo,
                              input logic [7:0] rows);
        write_reg(ktts_pkg::CFG_CURSOR_APP, {7'd0, cursor_app});
        write_reg(ktts_pkg::CFG_NEWLINE, {7'd0, newline});
        write_reg(ktts_pkg::CFG_LOCAL_ECHO, {7'd0, echo});
        write_reg(ktts_pkg::CFG_SCREEN_ROWS, rows);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        kif.valid        = 1'b0;
        kif.key_code     = '0;
        kif.pressed      = 1'b0;
        kif.shift_lock   = 1'b0;
        kif.shifted_code = '0;
        cycle_count      = 0;
        hold_request     = 1'b0;
        burst_left       = 4;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset register values
        send_key(16'h0000, 1'b1, 1'b0, 16'h0000);        // lowest code
        send_key(16'h00fe, 1'b1, 1'b0, 16'hffff);        // highest single-byte code
        send_key(KS_FIRST_SYM, 1'b1, 1'b0, 16'h0000);    // first keysym, not mapped
        send_key(KS_UNMAPPED, 1'b1, 1'b0, 16'h0000);
        send_key(KS_UP, 1'b1, 1'b0, 16'h0000);
        send_key(KS_DOWN, 1'b1, 1'b0, 16'h0000);
        send_key(KS_LEFT, 1'b1, 1'b0, 16'h0000);
        send_key(KS_RIGHT, 1'b1, 1'b0, 16'h0000);
        send_key(KS_BACKSPACE, 1'b1, 1'b0, 16'h0000);
        send_key(KS_TAB, 1'b1, 1'b0, 16'h0000);
        send_key(KS_ESCAPE, 1'b1, 1'b0, 16'h0000);
        send_key(KS_PAGE_DOWN, 1'b1, 1'b0, 16'h0000);    // no shift: plain sequence
        send_key(KS_PAGE_UP, 1'b1, 1'b0, 16'h0000);
        send_key(KS_END, 1'b1, 1'b0, 16'h0000);
        send_key(KS_HOME, 1'b1, 1'b0, 16'h0000);
        send_key(KS_DELETE, 1'b1, 1'b0, 16'h0000);
        send_key(KS_INSERT, 1'b1, 1'b0, 16'h0000);
        send_key(KS_ENTER, 1'b1, 1'b0, 16'h0000);
        send_key(KS_KP_ENTER, 1'b1, 1'b0, 16'h0000);
        // control letters, bracket and a neighbor of the upper range end
        send_key(KS_CTRL, 1'b1, 1'b0, 16'h0000);
        send_key({8'h00, "a"}, 1'b1, 1'b0, 16'h0000);
        send_key({8'h00, "z"}, 1'b1, 1'b0, 16'h0000);
        send_key({8'h00, "]"}, 1'b1, 1'b0, 16'h0000);
        send_key({8'h00, "{"}, 1'b1, 1'b0, 16'h0000);
        send_key({8'h00, "b"}, 1'b1, 1'b1, 16'hff41);    // shift lock beats control
        send_key(KS_CTRL, 1'b0, 1'b0, 16'h0000);
        send_key({8'h00, "q"}, 1'b0, 1'b0, 16'h0000);    // release makes nothing
        send_key(KS_SHIFT_L, 1'b1, 1'b0, 16'h0000);
        send_key(KS_PAGE_DOWN, 1'b1, 1'b0, 16'h0000);
        send_key(KS_PAGE_UP, 1'b1, 1'b0, 16'h0000);
        send_key(KS_SHIFT_L, 1'b0, 1'b0, 16'h0000);
        send_random(16);
        settle();

        // all modes on, largest screen; long output stall in the middle
        set_config(1'b1, 1'b1, 1'b1, 8'd255);
        send_key(KS_UP, 1'b1, 1'b0, 16'h0000);
        send_key(KS_ENTER, 1'b1, 1'b0, 16'h0000);
        send_random(10);
        hold_request = 1'b1;
        send_random(20);
        settle();

        // zero rows: shifted paging scrolls by nothing
        set_config(1'b0, 1'b0, 1'b1, 8'd0);
        send_key(KS_SHIFT_R, 1'b1, 1'b0, 16'h0000);
        send_key(KS_PAGE_DOWN, 1'b1, 1'b0, 16'h0000);
        send_key(KS_PAGE_UP, 1'b1, 1'b0, 16'h0000);
        send_random(15);
        settle();

        // one row: half rounds down to zero
        set_config(1'b1, 1'b0, 1'b0, 8'd1);
        send_random(15);
        settle();

        // odd screen height
        set_config(1'b0, 1'b1, 1'b0, 8'd77);
        send_key(KS_SHIFT_R, 1'b1, 1'b0, 16'h0000);
        send_key(KS_PAGE_DOWN, 1'b1, 1'b0, 16'h0000);
        send_random(15);
        settle();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/ktts_pkg.sv
hw/rtl/ktts_key_if.sv
hw/rtl/ktts_res_if.sv
hw/rtl/ktts_decode.sv
hw/rtl/ktts_serializer.sv
hw/rtl/key_to_terminal_sequence_unit.sv
test/key_to_terminal_sequence_unit_tb.sv
